### hw/rtl/packet_fifo_with_dedup_and_count_top_assert.svh
// Assertion macros for the packet FIFO with duplicate filter and counter
`ifndef PACKET_FIFO_WITH_DEDUP_AND_COUNT_TOP_ASSERT_SVH
`define PACKET_FIFO_WITH_DEDUP_AND_COUNT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define PF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pf_pkg.sv
// Shared types and constants for the packet FIFO with duplicate filter
`default_nettype none
package pf_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
	localparam int KIND_W = 2;
	localparam int ID_W = 16;
	localparam int TS_W = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD = 2'd0,
		KIND_FWD = 2'd1,
		KIND_CNT = 2'd2,
		KIND_NOP = 2'd3
	} kind_t;

	typedef struct packed {
		logic [ID_W-1:0] src;
		logic [ID_W-1:0] dst;
		logic [TS_W-1:0] ts;
	} pkt_t;

	typedef struct packed {
		logic [ID_W-1:0] src;
		logic [ID_W-1:0] dst;
		logic [TS_W-1:0] ts;
		logic [TS_W-1:0] t0;
		logic [TS_W-1:0] t1;
	} key_t;

	typedef struct packed {
		logic done;
		logic dup;
		logic [COUNT_W-1:0] count;
	} scan_sts_t;

endpackage
`default_nettype wire

### hw/rtl/pf_req_if.sv
// Request channel: command and packet fields with valid/ready
`default_nettype none
interface pf_req_if;
	logic valid;
	logic ready;
	logic [pf_pkg::KIND_W-1:0] kind;
	logic [pf_pkg::ID_W-1:0] source_id;
	logic [pf_pkg::ID_W-1:0] destination;
	logic [pf_pkg::TS_W-1:0] timestamp;
	logic [pf_pkg::TS_W-1:0] start_time;
	logic [pf_pkg::TS_W-1:0] end_time;

	modport source (output valid, kind, source_id, destination, timestamp, start_time, end_time,
		input ready);
	modport sink (input valid, kind, source_id, destination, timestamp, start_time, end_time,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/pf_rsp_if.sv
// Response channel: one result per request with valid/ready
`default_nettype none
interface pf_rsp_if;
	logic valid;
	logic ready;
	logic ok;
	logic [pf_pkg::ID_W-1:0] out_source;
	logic [pf_pkg::ID_W-1:0] out_destination;
	logic [pf_pkg::TS_W-1:0] out_timestamp;
	logic [pf_pkg::COUNT_W-1:0] match_count;

	modport source (output valid, ok, out_source, out_destination, out_timestamp, match_count,
		input ready);
	modport sink (input valid, ok, out_source, out_destination, out_timestamp, match_count,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/pf_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module pf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = pf_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/pf_scan.sv
// Scan unit: walks stored entries from the head, checks duplicates and counts matches
`default_nettype none
module pf_scan #(
	parameter int DEPTH = pf_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int OW = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [AW-1:0]     head,
	input  wire logic [OW-1:0]     len,
	input  wire pf_pkg::key_t      key,
	input  wire pf_pkg::pkt_t      rdata,
	output logic      [AW-1:0]     raddr,
	output pf_pkg::scan_sts_t      sts,
	output pf_pkg::pkt_t           pkt
);

	logic [AW-1:0] idx_q;
	logic [OW-1:0] rem_q;
	logic cmp_s1;
	logic last_s1;
	logic done_q;
	logic dup_q;
	logic [pf_pkg::COUNT_W-1:0] count_q;
	pf_pkg::pkt_t pkt_q;
	logic issue;
	logic same;
	logic hit;

	assign issue = (rem_q != '0);
	assign raddr = idx_q;

	assign same = (rdata.src == key.src) && (rdata.dst == key.dst) && (rdata.ts == key.ts);
	assign hit = (rdata.dst == key.dst) && (rdata.ts >= key.t0) && (rdata.ts <= key.t1);

	// Issue one read per cycle; compare each returned entry in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rem_q <= '0;
			cmp_s1 <= 1'b0;
			last_s1 <= 1'b0;
			done_q <= 1'b0;
			dup_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (start) begin
				idx_q <= head;
				rem_q <= len;
			end else if (issue) begin
				idx_q <= (idx_q == AW'(DEPTH - 1)) ? '0 : idx_q + 1'b1;
				rem_q <= rem_q - 1'b1;
			end
			cmp_s1 <= issue && !start;
			last_s1 <= issue && !start && (rem_q == OW'(1));
			done_q <= cmp_s1 && last_s1;
			if (start) begin
				dup_q <= 1'b0;
				count_q <= '0;
			end else if (cmp_s1) begin
				dup_q <= dup_q | same;
				count_q <= count_q + pf_pkg::COUNT_W'(hit);
			end
		end
	end

	// Hold the last entry read; a forward scans exactly the head entry
	always_ff @(posedge clk) begin
		if (cmp_s1) begin
			pkt_q <= rdata;
		end
	end

	assign sts.done = done_q;
	assign sts.dup = dup_q;
	assign sts.count = count_q;
	assign pkt = pkt_q;

endmodule
`default_nettype wire

### hw/rtl/packet_fifo_with_dedup_and_count_top.sv
// Top level of the bounded packet FIFO with duplicate filter and destination/time counter
//
// Usage:
//   req (valid/ready) carries one command: add a packet, forward the oldest, or count the
//   stored packets for a destination within an inclusive time window. rsp (valid/ready)
//   returns exactly one result per command, in order.
//   cfg_we/cfg_wdata write memory_limit; write it only while no command is in flight.
// Command flow:
//   An add or count walks every stored entry through the packet RAM read port, one entry
//   per cycle; a forward reads only the head entry. An add, count or forward on an empty
//   buffer, or a NOP, skips the scan and goes straight to the result. One command is
//   worked on at a time; the next transfer comes at the earliest in the cycle in which
//   the result is first presented.
// Reset:
//   arst_n empties the buffer (head, tail and occupancy zero) and sets memory_limit to
//   64. The packet RAM is not cleared; only occupied entries are ever read.
// Stall:
//   The result waits in an output register while rsp.ready is low. The next command is
//   still taken and worked on; its result holds until the output register frees up.
`default_nettype none
`include "packet_fifo_with_dedup_and_count_top_assert.svh"
module packet_fifo_with_dedup_and_count_top #(
	parameter int DEPTH = pf_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [pf_pkg::LIMIT_W-1:0]  cfg_wdata,
	pf_req_if.sink                           req,
	pf_rsp_if.source                         rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);
	localparam int CW = (OW > pf_pkg::LIMIT_W) ? OW : pf_pkg::LIMIT_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [pf_pkg::LIMIT_W-1:0] limit_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [OW-1:0] occ_q;
	pf_pkg::kind_t kind_q;
	pf_pkg::key_t key_q;

	logic out_valid_q;
	logic ok_q;
	pf_pkg::pkt_t out_pkt_q;
	logic [pf_pkg::COUNT_W-1:0] count_q;

	logic req_xfer;
	logic commit;
	logic out_free;
	logic scan_start;
	logic [OW-1:0] scan_len;
	logic [AW-1:0] raddr;
	pf_pkg::pkt_t rdata;
	pf_pkg::scan_sts_t sts;
	pf_pkg::pkt_t scan_pkt;
	logic nonempty;
	logic dup;
	logic full;
	logic add_ok;
	logic [AW-1:0] head_nx;
	logic [AW-1:0] tail_nx;
	pf_pkg::kind_t req_kind;

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer = req.valid && req.ready;
	assign req_kind = pf_pkg::kind_t'(req.kind);
	assign out_free = !out_valid_q || rsp.ready;
	assign commit = (state_q == S_DONE) && out_free;

	assign nonempty = (occ_q != '0);
	assign dup = nonempty && sts.dup;
	assign full = (occ_q >= OW'(DEPTH))
		|| ((limit_q != '0) && (CW'(occ_q) >= CW'(limit_q)))
		|| ((limit_q == '0) && nonempty);
	assign add_ok = !dup;
	assign head_nx = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// Scan length: all stored entries for add and count, the head entry for a forward
	always_comb begin
		case (req_kind)
			pf_pkg::KIND_ADD: scan_len = occ_q;
			pf_pkg::KIND_CNT: scan_len = occ_q;
			pf_pkg::KIND_FWD: scan_len = OW'(nonempty);
			default: scan_len = '0;
		endcase
	end
	assign scan_start = req_xfer && (scan_len != '0);

	// RAM writes only in S_DONE and reads only in S_SCAN, so the two never meet
	pf_ram #(
		.WIDTH($bits(pf_pkg::pkt_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (commit && (kind_q == pf_pkg::KIND_ADD) && add_ok),
		.waddr (tail_q),
		.wdata ({key_q.src, key_q.dst, key_q.ts}),
		.raddr (raddr),
		.rdata (rdata)
	);

	pf_scan #(
		.DEPTH(DEPTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.head   (head_q),
		.len    (scan_len),
		.key    (key_q),
		.rdata  (rdata),
		.raddr  (raddr),
		.sts    (sts),
		.pkt    (scan_pkt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pf_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Hold the command fields for the whole scan
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			kind_q <= req_kind;
			key_q.src <= req.source_id;
			key_q.dst <= req.destination;
			key_q.ts <= req.timestamp;
			key_q.t0 <= req.start_time;
			key_q.t1 <= req.end_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (scan_start) begin
						state_q <= S_SCAN;
					end else if (req_xfer) begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (sts.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Update the ring pointers when the result moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q <= '0;
		end else if (commit) begin
			case (kind_q)
				pf_pkg::KIND_ADD: begin
					if (add_ok) begin
						tail_q <= tail_nx;
						if (full) begin
							head_q <= head_nx;
						end else begin
							occ_q <= occ_q + 1'b1;
						end
					end
				end
				pf_pkg::KIND_FWD: begin
					if (nonempty) begin
						head_q <= head_nx;
						occ_q <= occ_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ok_q <= 1'b0;
			out_pkt_q <= '0;
			count_q <= '0;
			case (kind_q)
				pf_pkg::KIND_ADD: ok_q <= add_ok;
				pf_pkg::KIND_FWD: begin
					if (nonempty) begin
						ok_q <= 1'b1;
						out_pkt_q <= scan_pkt;
					end
				end
				pf_pkg::KIND_CNT: begin
					if (nonempty) begin
						count_q <= sts.count;
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.ok = ok_q;
	assign rsp.out_source = out_pkt_q.src;
	assign rsp.out_destination = out_pkt_q.dst;
	assign rsp.out_timestamp = out_pkt_q.ts;
	assign rsp.match_count = count_q;

	`PF_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OW'(DEPTH), "occupancy above depth")
	`PF_ASSERT_NOW(a_ring_meet, head_q != tail_q, nonempty && (occ_q != OW'(DEPTH)), "bad ring")
	`PF_ASSERT_NOW(a_done_in_scan, sts.done, state_q == S_SCAN, "scan finished outside scan state")
	`PF_ASSERT_NEXT(a_commit_shows, commit, out_valid_q, "result not presented after commit")

endmodule
`default_nettype wire
